// ===== hdl/vmt_pkg.sv =====
`timescale 1ns / 1ps

package vmt_pkg;

	localparam int LANES       = 4;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_BITS    = 34;
	// pipeline positions, counted in register stages from the input
	localparam int SUM_AT      = 3;
	localparam int LEN_AT      = SUM_AT + SQRT_STAGES;
	localparam int RES_AT      = LEN_AT + DIV_BITS + 3;

	typedef logic signed [31:0] fix_t;
	typedef logic signed [32:0] diff_t;

	typedef struct packed {
		logic [LANES-1:0][31:0] cur;
		logic [LANES-1:0][31:0] goal;
		logic [31:0]            step;
	} side_t;

endpackage

// ===== hdl/vmt_lane_sq.sv =====
`timescale 1ns / 1ps

module vmt_lane_sq (
	input  logic                 clk,
	input  logic                 en,
	input  vmt_pkg::fix_t        cur,
	input  vmt_pkg::fix_t        goal,
	output vmt_pkg::diff_t       d_s1,
	output logic [64:0]          sq_s2
);
	import vmt_pkg::*;

	logic [32:0] mag;

	assign mag = d_s1[32] ? 33'(-d_s1) : 33'(d_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= 33'(goal) - 33'(cur);
			sq_s2 <= 65'(66'(mag) * 66'(mag));
		end
	end

endmodule

// ===== hdl/vmt_isqrt.sv =====
`timescale 1ns / 1ps

module vmt_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] sq,
	output logic [31:0] len
);
	import vmt_pkg::*;

	logic [63:0] rem_s  [SQRT_STAGES+1];
	logic [63:0] root_s [SQRT_STAGES+1];

	assign rem_s[0]  = sq;
	assign root_s[0] = '0;

	// one result bit per stage, trial bit walks down two places a stage
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = root_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign len = root_s[SQRT_STAGES][31:0];

endmodule

// ===== hdl/vmt_lane_div.sv =====
`timescale 1ns / 1ps

module vmt_lane_div (
	input  logic           clk,
	input  logic           en,
	input  vmt_pkg::diff_t d,
	input  vmt_pkg::fix_t  step,
	input  vmt_pkg::fix_t  cur,
	input  logic [31:0]    len,
	output vmt_pkg::fix_t  res
);
	import vmt_pkg::*;

	localparam logic [DIV_BITS-1:0] QMAX = DIV_BITS'(1) << (DIV_BITS - 1);

	logic [32:0] dmag;
	logic [31:0] smag;
	logic [64:0] prod_s1;
	logic [31:0] len_s1;
	logic        neg_s1;
	fix_t        cur_s1;

	logic [31:0]         rem_s  [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_s  [DIV_BITS+1];
	logic [DIV_BITS-1:0] plo_s  [DIV_BITS+1];
	logic [31:0]         len_s  [DIV_BITS+1];
	logic                ovf_s  [DIV_BITS+1];
	logic                neg_s  [DIV_BITS+1];
	fix_t                cur_s  [DIV_BITS+1];

	logic [DIV_BITS-1:0] qc;
	logic signed [35:0]  sum;

	assign dmag = d[32] ? 33'(-d) : 33'(d);
	assign smag = step[31] ? 32'(-step) : 32'(step);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 65'(dmag) * 65'(smag);
			len_s1  <= (len == '0) ? 32'd1 : len;
			neg_s1  <= d[32] ^ step[31];
			cur_s1  <= cur;
			// high part at or above len means quotient beyond the clamp
			ovf_s[0] <= 32'(prod_s1[64:DIV_BITS]) >= len_s1;
			rem_s[0] <= 32'(prod_s1[64:DIV_BITS]);
			quo_s[0] <= '0;
			plo_s[0] <= prod_s1[DIV_BITS-1:0];
			len_s[0] <= len_s1;
			neg_s[0] <= neg_s1;
			cur_s[0] <= cur_s1;
		end
	end

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
		logic [32:0] trial;
		assign trial = {rem_s[j], plo_s[j][DIV_BITS-1-j]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= 33'(len_s[j])) begin
					rem_s[j+1] <= 32'(trial - 33'(len_s[j]));
					quo_s[j+1] <= {quo_s[j][DIV_BITS-2:0], 1'b1};
				end else begin
					rem_s[j+1] <= trial[31:0];
					quo_s[j+1] <= {quo_s[j][DIV_BITS-2:0], 1'b0};
				end
				plo_s[j+1] <= plo_s[j];
				len_s[j+1] <= len_s[j];
				ovf_s[j+1] <= ovf_s[j];
				neg_s[j+1] <= neg_s[j];
				cur_s[j+1] <= cur_s[j];
			end
		end
	end

	assign qc  = (ovf_s[DIV_BITS] || quo_s[DIV_BITS] > QMAX) ? QMAX : quo_s[DIV_BITS];
	assign sum = neg_s[DIV_BITS] ? 36'(cur_s[DIV_BITS]) - 36'({1'b0, qc})
		: 36'(cur_s[DIV_BITS]) + 36'({1'b0, qc});

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum > 36'sd2147483647)
				res <= 32'sh7fffffff;
			else if (sum < -36'sd2147483648)
				res <= 32'sh80000000;
			else
				res <= sum[31:0];
		end
	end

endmodule

// ===== hdl/vec4_move_towards_top.sv =====
`timescale 1ns / 1ps
// Pipeline: 73 register stages from input accept to out_valid (3 front stages, 32 square-root
// stages, 37 stages of product, 34-step division and saturation, one output register).
// Throughput: one item per cycle; the whole pipeline advances unless the output
// register holds an item that is stalled.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module vec4_move_towards_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vmt_pkg::fix_t cur_x,
	input  vmt_pkg::fix_t cur_y,
	input  vmt_pkg::fix_t cur_z,
	input  vmt_pkg::fix_t cur_w,
	input  vmt_pkg::fix_t goal_x,
	input  vmt_pkg::fix_t goal_y,
	input  vmt_pkg::fix_t goal_z,
	input  vmt_pkg::fix_t goal_w,
	input  vmt_pkg::fix_t step_max,
	output logic          out_valid,
	input  logic          out_stall,
	output vmt_pkg::fix_t out_x,
	output vmt_pkg::fix_t out_y,
	output vmt_pkg::fix_t out_z,
	output vmt_pkg::fix_t out_w,
	output logic          reached
);
	import vmt_pkg::*;

	logic                 adv;
	logic [RES_AT:1]      vld_q;
	side_t                side_in;
	side_t                side_q [1:RES_AT];
	diff_t                d_lane [LANES];
	logic [64:0]          sq_lane [LANES];
	diff_t                d_q [2:LEN_AT][LANES];
	logic [62:0]          stepsq_s2;
	logic [66:0]          sum_all;
	logic [63:0]          sq_s3;
	logic                 snap_q [SUM_AT:RES_AT];
	logic [31:0]          len;
	fix_t                 res [LANES];
	fix_t                 out_q [LANES];
	logic                 hit;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	assign side_in.cur  = {cur_w, cur_z, cur_y, cur_x};
	assign side_in.goal = {goal_w, goal_z, goal_y, goal_x};
	assign side_in.step = step_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[RES_AT-1:1], in_valid};
			out_valid <= vld_q[RES_AT];
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_sq
		vmt_lane_sq u_sq (
			.clk  (clk),
			.en   (adv),
			.cur  (fix_t'(side_in.cur[i])),
			.goal (fix_t'(side_in.goal[i])),
			.d_s1 (d_lane[i]),
			.sq_s2(sq_lane[i])
		);
	end

	assign sum_all = 67'(sq_lane[0]) + 67'(sq_lane[1]) + 67'(sq_lane[2]) + 67'(sq_lane[3]);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[1] <= side_in;
			for (int k = 2; k <= RES_AT; k++)
				side_q[k] <= side_q[k-1];
			d_q[2] <= d_lane;
			for (int k = 3; k <= LEN_AT; k++)
				d_q[k] <= d_q[k-1];
			stepsq_s2 <= 63'($signed(side_q[1].step) * $signed(side_q[1].step));
			// squared length saturates at all ones
			sq_s3 <= (sum_all[66:64] != '0) ? '1 : sum_all[63:0];
			snap_q[SUM_AT] <= (sum_all == '0) || (!side_q[2].step[31]
				&& sum_all <= 67'(stepsq_s2));
			for (int k = SUM_AT + 1; k <= RES_AT; k++)
				snap_q[k] <= snap_q[k-1];
		end
	end

	vmt_isqrt u_isqrt (
		.clk(clk),
		.en (adv),
		.sq (sq_s3),
		.len(len)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_div
		vmt_lane_div u_div (
			.clk (clk),
			.en  (adv),
			.d   (d_q[LEN_AT][i]),
			.step(fix_t'(side_q[LEN_AT].step)),
			.cur (fix_t'(side_q[LEN_AT].cur[i])),
			.len (len),
			.res (res[i])
		);
	end

	// merge: pick the target on a snap, then compare all lanes against it
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			out_q[i] = snap_q[RES_AT] ? fix_t'(side_q[RES_AT].goal[i]) : res[i];
			if (out_q[i] != fix_t'(side_q[RES_AT].goal[i]))
				hit = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x   <= out_q[0];
			out_y   <= out_q[1];
			out_z   <= out_q[2];
			out_w   <= out_q[3];
			reached <= hit;
		end
	end

endmodule

// ===== hdl/vmt_checker.sv =====
`timescale 1ns / 1ps

module vmt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_stall_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind vec4_move_towards_top vmt_checker u_vmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall)
);
